FILE: sv/wdes_pkg.sv
// Shared types and constants for the walk detector.
package wdes_pkg;

  // Field widths
  localparam int RAW_W      = 16;
  localparam int CAL_W      = 16;
  localparam int CAL_SHIFT  = 16;
  localparam int GAIN_W     = 24;
  localparam int THR_W      = 16;
  localparam int ENERGY_W   = 16;
  localparam int SPLIT_W    = 24;
  localparam int MUL_MIN_W  = GAIN_W + 1;

  localparam int WINDOW_LENGTH_DEF = 80;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_G_OFFSET  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_G_SCALE_GAIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WALK_THRESHOLD = 2'd2;

  localparam logic [RAW_W-1:0]  ZERO_G_OFFSET_RST  = 16'd0;
  localparam logic [GAIN_W-1:0] G_SCALE_GAIN_RST   = 24'd65536;
  localparam logic [THR_W-1:0]  WALK_THRESHOLD_RST = 16'd154;

  // One datapath step per cycle of the sequencer
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAL_X,
    OP_CAL_Y,
    OP_CAL_Z,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_Z,
    OP_OLD_SQ,
    OP_NEW_SQ,
    OP_SUM_SQ,
    OP_N_LO,
    OP_N_HI,
    OP_T_N,
    OP_T_SQ,
    OP_COMPARE
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL_X,
    ST_CAL_Y,
    ST_CAL_Z,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_OLD_SQ,
    ST_NEW_SQ,
    ST_SUM_SQ,
    ST_N_LO,
    ST_N_HI,
    ST_T_N,
    ST_T_SQ,
    ST_COMPARE,
    ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_load;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/wdes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module wdes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/wdes_ctrl.sv
// Sequencer for the walk detector: steps the datapath through one request.
module wdes_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wdes_pkg::dp_status_t status,
  output wdes_pkg::dp_cmd_t    cmd
);

  wdes_pkg::state_t state_r;
  wdes_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wdes_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wdes_pkg::ST_IDLE:    if (in_valid) state_nxt = wdes_pkg::ST_CAL_X;
      wdes_pkg::ST_CAL_X:   state_nxt = wdes_pkg::ST_CAL_Y;
      wdes_pkg::ST_CAL_Y:   state_nxt = wdes_pkg::ST_CAL_Z;
      wdes_pkg::ST_CAL_Z:   state_nxt = wdes_pkg::ST_SQ_X;
      wdes_pkg::ST_SQ_X:    state_nxt = wdes_pkg::ST_SQ_Y;
      wdes_pkg::ST_SQ_Y:    state_nxt = wdes_pkg::ST_SQ_Z;
      wdes_pkg::ST_SQ_Z:    state_nxt = wdes_pkg::ST_OLD_SQ;
      wdes_pkg::ST_OLD_SQ:  state_nxt = wdes_pkg::ST_NEW_SQ;
      wdes_pkg::ST_NEW_SQ:  state_nxt = wdes_pkg::ST_SUM_SQ;
      wdes_pkg::ST_SUM_SQ:  state_nxt = wdes_pkg::ST_N_LO;
      wdes_pkg::ST_N_LO:    state_nxt = wdes_pkg::ST_N_HI;
      wdes_pkg::ST_N_HI:    state_nxt = wdes_pkg::ST_T_N;
      wdes_pkg::ST_T_N:     state_nxt = wdes_pkg::ST_T_SQ;
      wdes_pkg::ST_T_SQ:    state_nxt = wdes_pkg::ST_COMPARE;
      wdes_pkg::ST_COMPARE: state_nxt = wdes_pkg::ST_OUT;
      // hold until the output register can take the result
      wdes_pkg::ST_OUT:     if (status.out_free) state_nxt = wdes_pkg::ST_IDLE;
      default:              state_nxt = wdes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == wdes_pkg::ST_IDLE);
    cmd.in_load  = (state_r == wdes_pkg::ST_IDLE) && in_valid;
    cmd.out_load = (state_r == wdes_pkg::ST_OUT) && status.out_free;
    case (state_r)
      wdes_pkg::ST_CAL_X:   cmd.op = wdes_pkg::OP_CAL_X;
      wdes_pkg::ST_CAL_Y:   cmd.op = wdes_pkg::OP_CAL_Y;
      wdes_pkg::ST_CAL_Z:   cmd.op = wdes_pkg::OP_CAL_Z;
      wdes_pkg::ST_SQ_X:    cmd.op = wdes_pkg::OP_SQ_X;
      wdes_pkg::ST_SQ_Y:    cmd.op = wdes_pkg::OP_SQ_Y;
      wdes_pkg::ST_SQ_Z:    cmd.op = wdes_pkg::OP_SQ_Z;
      wdes_pkg::ST_OLD_SQ:  cmd.op = wdes_pkg::OP_OLD_SQ;
      wdes_pkg::ST_NEW_SQ:  cmd.op = wdes_pkg::OP_NEW_SQ;
      wdes_pkg::ST_SUM_SQ:  cmd.op = wdes_pkg::OP_SUM_SQ;
      wdes_pkg::ST_N_LO:    cmd.op = wdes_pkg::OP_N_LO;
      wdes_pkg::ST_N_HI:    cmd.op = wdes_pkg::OP_N_HI;
      wdes_pkg::ST_T_N:     cmd.op = wdes_pkg::OP_T_N;
      wdes_pkg::ST_T_SQ:    cmd.op = wdes_pkg::OP_T_SQ;
      wdes_pkg::ST_COMPARE: cmd.op = wdes_pkg::OP_COMPARE;
      default:              cmd.op = wdes_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: sv/wdes_dp.sv
// Datapath for the walk detector: shared multiplier, window statistics, config and output.
module wdes_dp #(
  parameter int WINDOW_LENGTH = wdes_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wdes_pkg::dp_cmd_t                 cmd,
  output wdes_pkg::dp_status_t              status,
  input  logic [wdes_pkg::RAW_W-1:0]        in_raw_x,
  input  logic [wdes_pkg::RAW_W-1:0]        in_raw_y,
  input  logic [wdes_pkg::RAW_W-1:0]        in_raw_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_walking,
  output logic [wdes_pkg::ENERGY_W-1:0]     out_sample_energy,
  input  logic                              cfg_we,
  input  logic [wdes_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wdes_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RAW_W    = wdes_pkg::RAW_W;
  localparam int CAL_W    = wdes_pkg::CAL_W;
  localparam int ENERGY_W = wdes_pkg::ENERGY_W;
  localparam int GAIN_W   = wdes_pkg::GAIN_W;
  localparam int THR_W    = wdes_pkg::THR_W;
  localparam int LO_W     = wdes_pkg::SPLIT_W;
  localparam int DX_W     = RAW_W + 1;
  localparam int ACC_W    = 2 * CAL_W;
  localparam int IDX_W    = $clog2(WINDOW_LENGTH);
  localparam int NW       = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W    = ENERGY_W + IDX_W;
  localparam int SQ_W     = 2 * ENERGY_W + IDX_W;
  localparam int HI_W     = SQ_W - LO_W;
  localparam int TN_W     = THR_W + NW;
  localparam int LHS_W    = SQ_W + NW;
  localparam int RHS_W    = 2 * TN_W;
  localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int MW       = (TN_W + 1 > wdes_pkg::MUL_MIN_W) ? TN_W + 1 : wdes_pkg::MUL_MIN_W;
  localparam int PW       = 2 * MW;
  localparam int SAT_LO   = wdes_pkg::CAL_SHIFT + CAL_W - 1;

  localparam logic [NW-1:0]    N_VAL    = NW'(WINDOW_LENGTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);

  // Saturate floor(p / 2^16) to the signed calibrated range
  function automatic logic [CAL_W-1:0] sat_cal(input logic [PW-1:0] p);
    logic [PW-1-SAT_LO:0] hi;
    logic [CAL_W-1:0]     q;
    hi = p[PW-1:SAT_LO];
    if ((hi == '0) || (hi == '1)) begin
      q = p[SAT_LO:wdes_pkg::CAL_SHIFT];
    end else if (p[PW-1]) begin
      q = {1'b1, {(CAL_W-1){1'b0}}};
    end else begin
      q = {1'b0, {(CAL_W-1){1'b1}}};
    end
    return q;
  endfunction

  // Configuration registers
  logic [RAW_W-1:0]  zero_r,  zero_nxt;
  logic [GAIN_W-1:0] gain_r,  gain_nxt;
  logic [THR_W-1:0]  thr_r,   thr_nxt;

  // Request payload and intermediate values
  logic [RAW_W-1:0]    raw_x_r, raw_y_r, raw_z_r;
  logic [RAW_W-1:0]    raw_x_nxt, raw_y_nxt, raw_z_nxt;
  logic [CAL_W-1:0]    cal_x_r, cal_y_r, cal_z_r;
  logic [CAL_W-1:0]    cal_x_nxt, cal_y_nxt, cal_z_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [LHS_W-1:0]    lhs_r, lhs_nxt;
  logic                walk_r, walk_nxt;

  // Window state
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic             filled_r, filled_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_walking_r, out_walking_nxt;
  logic [ENERGY_W-1:0] out_energy_r, out_energy_nxt;

  // Shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;

  logic [RAW_W-1:0]    raw_sel;
  logic [DX_W-1:0]     dx;
  logic [ACC_W-1:0]    e_sum;
  logic [ENERGY_W-1:0] ram_rdata;
  logic [ENERGY_W-1:0] old;
  logic                ram_we;

  assign status.out_free   = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_walking       = out_walking_r;
  assign out_sample_energy = out_energy_r;

  // Entries ahead of the pointer read as zero until the window first wraps
  assign old   = filled_r ? ram_rdata : '0;
  assign e_sum = acc_r + prod_r[ACC_W-1:0];

  wdes_ram #(
    .WIDTH(ENERGY_W),
    .DEPTH(WINDOW_LENGTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr_r),
    .wdata(energy_r),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (cmd.op)
      wdes_pkg::OP_CAL_Y: raw_sel = raw_y_r;
      wdes_pkg::OP_CAL_Z: raw_sel = raw_z_r;
      default:            raw_sel = raw_x_r;
    endcase
    dx = {raw_sel[RAW_W-1], raw_sel} - {zero_r[RAW_W-1], zero_r};
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      wdes_pkg::OP_CAL_X, wdes_pkg::OP_CAL_Y, wdes_pkg::OP_CAL_Z: begin
        mul_a = {{(MW-DX_W){dx[DX_W-1]}}, dx};
        mul_b = {{(MW-GAIN_W){gain_r[GAIN_W-1]}}, gain_r};
      end
      wdes_pkg::OP_SQ_X: begin
        mul_a = {{(MW-CAL_W){cal_x_r[CAL_W-1]}}, cal_x_r};
        mul_b = mul_a;
      end
      wdes_pkg::OP_SQ_Y: begin
        mul_a = {{(MW-CAL_W){cal_y_r[CAL_W-1]}}, cal_y_r};
        mul_b = mul_a;
      end
      wdes_pkg::OP_SQ_Z: begin
        mul_a = {{(MW-CAL_W){cal_z_r[CAL_W-1]}}, cal_z_r};
        mul_b = mul_a;
      end
      wdes_pkg::OP_OLD_SQ: begin
        mul_a = {{(MW-ENERGY_W){1'b0}}, old};
        mul_b = mul_a;
      end
      wdes_pkg::OP_NEW_SQ: begin
        mul_a = {{(MW-ENERGY_W){1'b0}}, energy_r};
        mul_b = mul_a;
      end
      wdes_pkg::OP_SUM_SQ: begin
        mul_a = {{(MW-SUM_W){1'b0}}, sum_r};
        mul_b = mul_a;
      end
      wdes_pkg::OP_N_LO: begin
        mul_a = {{(MW-NW){1'b0}}, N_VAL};
        mul_b = {{(MW-LO_W){1'b0}}, sq_r[LO_W-1:0]};
      end
      wdes_pkg::OP_N_HI: begin
        mul_a = {{(MW-NW){1'b0}}, N_VAL};
        mul_b = {{(MW-HI_W){1'b0}}, sq_r[SQ_W-1:LO_W]};
      end
      wdes_pkg::OP_T_N: begin
        mul_a = {{(MW-THR_W){1'b0}}, thr_r};
        mul_b = {{(MW-NW){1'b0}}, N_VAL};
      end
      wdes_pkg::OP_T_SQ: begin
        mul_a = {{(MW-TN_W){1'b0}}, prod_r[TN_W-1:0]};
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    zero_nxt        = zero_r;
    gain_nxt        = gain_r;
    thr_nxt         = thr_r;
    raw_x_nxt       = raw_x_r;
    raw_y_nxt       = raw_y_r;
    raw_z_nxt       = raw_z_r;
    cal_x_nxt       = cal_x_r;
    cal_y_nxt       = cal_y_r;
    cal_z_nxt       = cal_z_r;
    acc_nxt         = acc_r;
    energy_nxt      = energy_r;
    lhs_nxt         = lhs_r;
    walk_nxt        = walk_r;
    ptr_nxt         = ptr_r;
    filled_nxt      = filled_r;
    sum_nxt         = sum_r;
    sq_nxt          = sq_r;
    out_walking_nxt = out_walking_r;
    out_energy_nxt  = out_energy_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    ram_we          = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        wdes_pkg::REG_ZERO_G_OFFSET:  zero_nxt = cfg_data[RAW_W-1:0];
        wdes_pkg::REG_G_SCALE_GAIN:   gain_nxt = cfg_data[GAIN_W-1:0];
        wdes_pkg::REG_WALK_THRESHOLD: thr_nxt  = cfg_data[THR_W-1:0];
        default: ;
      endcase
    end

    if (cmd.in_load) begin
      raw_x_nxt = in_raw_x;
      raw_y_nxt = in_raw_y;
      raw_z_nxt = in_raw_z;
    end

    if (cmd.out_load) begin
      out_valid_nxt   = 1'b1;
      out_walking_nxt = walk_r;
      out_energy_nxt  = energy_r;
    end

    // Each step after the first consumes the product of the step before
    case (cmd.op)
      wdes_pkg::OP_CAL_Y:  cal_x_nxt = sat_cal(prod_r);
      wdes_pkg::OP_CAL_Z:  cal_y_nxt = sat_cal(prod_r);
      wdes_pkg::OP_SQ_X:   cal_z_nxt = sat_cal(prod_r);
      wdes_pkg::OP_SQ_Y:   acc_nxt   = prod_r[ACC_W-1:0];
      wdes_pkg::OP_SQ_Z:   acc_nxt   = e_sum;
      wdes_pkg::OP_OLD_SQ: energy_nxt = e_sum[ACC_W-1:ACC_W-ENERGY_W];
      wdes_pkg::OP_NEW_SQ: begin
        sq_nxt     = sq_r - SQ_W'(prod_r[ACC_W-1:0]);
        sum_nxt    = sum_r - SUM_W'(old) + SUM_W'(energy_r);
        ram_we     = 1'b1;
        ptr_nxt    = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
        filled_nxt = filled_r || (ptr_r == LAST_IDX);
      end
      wdes_pkg::OP_SUM_SQ: sq_nxt  = sq_r + SQ_W'(prod_r[ACC_W-1:0]);
      wdes_pkg::OP_N_LO:   lhs_nxt = LHS_W'(0) - LHS_W'(prod_r[2*SUM_W-1:0]);
      wdes_pkg::OP_N_HI:   lhs_nxt = lhs_r + LHS_W'(prod_r[LO_W+NW-1:0]);
      wdes_pkg::OP_T_N:    lhs_nxt = lhs_r + {prod_r[HI_W+NW-1:0], {LO_W{1'b0}}};
      wdes_pkg::OP_COMPARE: begin
        walk_nxt = CMP_W'(lhs_r) > CMP_W'(prod_r[RHS_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r      <= wdes_pkg::ZERO_G_OFFSET_RST;
      gain_r      <= wdes_pkg::G_SCALE_GAIN_RST;
      thr_r       <= wdes_pkg::WALK_THRESHOLD_RST;
      ptr_r       <= '0;
      filled_r    <= 1'b0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      zero_r      <= zero_nxt;
      gain_r      <= gain_nxt;
      thr_r       <= thr_nxt;
      ptr_r       <= ptr_nxt;
      filled_r    <= filled_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r        <= mul_a * mul_b;
    raw_x_r       <= raw_x_nxt;
    raw_y_r       <= raw_y_nxt;
    raw_z_r       <= raw_z_nxt;
    cal_x_r       <= cal_x_nxt;
    cal_y_r       <= cal_y_nxt;
    cal_z_r       <= cal_z_nxt;
    acc_r         <= acc_nxt;
    energy_r      <= energy_nxt;
    lhs_r         <= lhs_nxt;
    walk_r        <= walk_nxt;
    out_walking_r <= out_walking_nxt;
    out_energy_r  <= out_energy_nxt;
  end

endmodule

FILE: sv/walk_detector_energy_stddev.sv
// Top level of the walk detector: sequencer plus datapath.
//
//  Channel | Ports                                      | Direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_raw_x/y/z           | request in
//  out     | out_valid, out_ready, out_walking,         | result out
//          | out_sample_energy                          |
//  cfg     | cfg_we, cfg_index, cfg_data                | write only
//
// A request steps through the calibrate, square, window and compare states before its
// result sits in the output register, and no new request is accepted until the sequencer
// is back in idle: 13 products go one per cycle through a single shared 25x25 multiplier.
// Reset is synchronous; the window reads as zero until its pointer first wraps,
// tracked by a fill flag, so there is no clearing pass after reset.
// A waiting result does not block acceptance of the next request; the sequencer
// holds only if the previous result is still not taken when the new one is done.
module walk_detector_energy_stddev #(
  parameter int WINDOW_LENGTH = wdes_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wdes_pkg::RAW_W-1:0]        in_raw_x,
  input  logic [wdes_pkg::RAW_W-1:0]        in_raw_y,
  input  logic [wdes_pkg::RAW_W-1:0]        in_raw_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_walking,
  output logic [wdes_pkg::ENERGY_W-1:0]     out_sample_energy,
  input  logic                              cfg_we,
  input  logic [wdes_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wdes_pkg::CFG_DATA_W-1:0]   cfg_data
);

  wdes_pkg::dp_cmd_t    cmd;
  wdes_pkg::dp_status_t status;

  wdes_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  wdes_dp #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_raw_x         (in_raw_x),
    .in_raw_y         (in_raw_y),
    .in_raw_z         (in_raw_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_walking      (out_walking),
    .out_sample_energy(out_sample_energy),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule

FILE: tb/walk_detector_energy_stddev_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the walk detector: directed table, then random motion phases.
module walk_detector_energy_stddev_test;
  import wdes_pkg::*;

  localparam int WIN_LEN         = WINDOW_LENGTH_DEF;
  localparam int BLOCK_LATENCY   = 16;
  localparam int IDLE_LIMIT      = 4000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PHASE_COUNT     = 7;
  localparam int PHASE_ITEMS     = 270;
  localparam int PRINT_CAP       = 40;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [RAW_W-1:0]        x, y, z;
    logic [CFG_INDEX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    bit                      fixed;
    logic                    walking;
    logic [ENERGY_W-1:0]     energy;
  } stim_row_t;

  typedef struct {
    logic                walking;
    logic [ENERGY_W-1:0] energy;
  } walk_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [RAW_W-1:0]       in_raw_x = '0;
  logic [RAW_W-1:0]       in_raw_y = '0;
  logic [RAW_W-1:0]       in_raw_z = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_walking;
  logic [ENERGY_W-1:0]    out_sample_energy;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state: energy window with running sums, plus register copies
  logic [ENERGY_W-1:0] energy_hist [WIN_LEN];
  int                  hist_pos = 0;
  longint unsigned     energy_sum = 0;
  longint unsigned     energy_sq_sum = 0;
  longint signed       zero_g = longint'($signed(ZERO_G_OFFSET_RST));
  longint signed       gain = longint'($signed(G_SCALE_GAIN_RST));
  longint unsigned     walk_thr = longint'(WALK_THRESHOLD_RST);

  walk_result_t walk_results_due[$];
  int           mismatch_count = 0;
  int           results_taken = 0;
  int           stuck_cycles = 0;
  bit           pressure_done = 1'b0;
  bit           moving = 1'b0;
  int           motion_left = 0;

  walk_detector_energy_stddev dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_x         (in_raw_x),
    .in_raw_y         (in_raw_y),
    .in_raw_z         (in_raw_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_walking      (out_walking),
    .out_sample_energy(out_sample_energy),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch at result %0d: %s got %0d, expected %0d", results_taken, what, got,
               want);
    end
  endtask

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ZERO_G_OFFSET:  zero_g = longint'($signed(data[RAW_W-1:0]));
      REG_G_SCALE_GAIN:   gain = longint'($signed(data[GAIN_W-1:0]));
      REG_WALK_THRESHOLD: walk_thr = longint'(data[THR_W-1:0]);
      default: ;
    endcase
  endfunction

  // Remove offset, scale, floor to Q3.12 g and saturate
  function automatic longint signed scale_axis(logic [RAW_W-1:0] raw);
    longint signed q;
    q = ((longint'($signed(raw)) - zero_g) * gain) >>> CAL_SHIFT;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic walk_result_t predict_walk(logic [RAW_W-1:0] rx, ry, rz);
    longint signed   ax, ay, az;
    longint unsigned mag, old, spread, limit;
    walk_result_t    r;
    ax = scale_axis(rx);
    ay = scale_axis(ry);
    az = scale_axis(rz);
    mag = ax * ax + ay * ay + az * az;
    mag = mag >> 16;
    if (mag > 65535) mag = 65535;
    old = energy_hist[hist_pos];
    energy_hist[hist_pos] = mag[ENERGY_W-1:0];
    hist_pos = (hist_pos == WIN_LEN - 1) ? 0 : hist_pos + 1;
    energy_sum = energy_sum - old + mag;
    energy_sq_sum = energy_sq_sum - old * old + mag * mag;
    // Variance test without root or division: N*sumsq - sum^2 > (t*N)^2
    spread = longint'(WIN_LEN) * energy_sq_sum - energy_sum * energy_sum;
    limit = walk_thr * longint'(WIN_LEN);
    limit = limit * limit;
    r.walking = (spread > limit);
    r.energy = mag[ENERGY_W-1:0];
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 40));
  endfunction

  function automatic logic [RAW_W-1:0] clip_raw(int v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[RAW_W-1:0];
  endfunction

  // Alternate still and walking stretches around 1 g on z, with some full-range noise
  function automatic void motion_sample(output logic [RAW_W-1:0] x, y, z);
    int spread, base;
    if (motion_left == 0) begin
      moving = ~moving;
      motion_left = int'($urandom_range(40, 160));
    end
    motion_left--;
    spread = moving ? 6000 : 40;
    base = int'(zero_g);
    if ($urandom_range(0, 9) == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end else begin
      x = clip_raw(base + int'($urandom_range(0, 2 * spread)) - spread);
      y = clip_raw(base + int'($urandom_range(0, 2 * spread)) - spread);
      z = clip_raw(base + 4096 + int'($urandom_range(0, 2 * spread)) - spread);
    end
  endfunction

  function automatic stim_row_t sample_row(logic [RAW_W-1:0] x, y, z);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, x: x, y: y, z: z, reg_idx: '0, reg_val: '0, fixed: 1'b0,
            walking: 1'b0, energy: '0};
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic [RAW_W-1:0] x, y, z, logic walking,
                                            logic [ENERGY_W-1:0] energy);
    stim_row_t row;
    row = sample_row(x, y, z);
    row.fixed = 1'b1;
    row.walking = walking;
    row.energy = energy;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = sample_row('0, '0, '0);
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic send_sample(logic [RAW_W-1:0] x, y, z, int gap, bit fixed,
                             walk_result_t fixed_res);
    walk_result_t r;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    do @(posedge clk); while (!in_ready);
    r = predict_walk(x, y, z);
    walk_results_due.push_back(fixed ? fixed_res : r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
  endtask

  // Hold cfg_we high across back-to-back writes; close_reg_writes drops it
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    apply_reg(idx, data);
  endtask

  task automatic close_reg_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : check_result
    walk_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (walk_results_due.size() == 0) begin
        report_mismatch("result with no request pending", out_sample_energy, 0);
      end else begin
        want = walk_results_due.pop_front();
        if (out_walking !== want.walking)
          report_mismatch("walking", out_walking, want.walking);
        if (out_sample_energy !== want.energy)
          report_mismatch("sample_energy", out_sample_energy, want.energy);
        results_taken++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    wait (rst_n);
    @(negedge clk);
    forever begin
      hold = idle_gap();
      // One long hold-off so the block backs up and stalls new requests
      if (!pressure_done && results_taken >= 500) begin
        hold = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12))
        @(negedge clk);
    end
  end

  initial begin : stimulus
    stim_row_t             rows[$];
    walk_result_t          fixed_res;
    logic [RAW_W-1:0]      sx, sy, sz;
    logic [CFG_DATA_W-1:0] zero_v, gain_v, thr_v;

    foreach (energy_hist[i]) energy_hist[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers give unit gain, so raw counts are Q3.12 g directly
    rows.push_back(checked_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0));
    rows.push_back(checked_row(16'h8000, 16'h8000, 16'h8000, 1'b1, 16'd49152));
    rows.push_back(checked_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'd49149));
    rows.push_back(checked_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd0));
    rows.push_back(sample_row(16'h8000, 16'h0000, 16'h7FFF));
    rows.push_back(sample_row(16'h0001, 16'hFFFF, 16'h0000));
    rows.push_back(sample_row(16'h1000, 16'hF000, 16'h1000));
    rows.push_back(reg_row(REG_UNMAPPED, 24'hFFFFFF));
    rows.push_back(sample_row(16'h1000, 16'h0000, 16'h0000));
    rows.push_back(reg_row(REG_G_SCALE_GAIN, 24'h7FFFFF));
    rows.push_back(sample_row(16'h0001, 16'hFFFF, 16'h0000));
    rows.push_back(sample_row(16'h7FFF, 16'h8000, 16'h0100));
    rows.push_back(reg_row(REG_G_SCALE_GAIN, 24'h800000));
    rows.push_back(sample_row(16'h7FFF, 16'h8000, 16'h0001));
    rows.push_back(reg_row(REG_ZERO_G_OFFSET, 24'h007FFF));
    rows.push_back(sample_row(16'h8000, 16'h7FFF, 16'h0000));
    rows.push_back(reg_row(REG_ZERO_G_OFFSET, 24'h008000));
    rows.push_back(sample_row(16'h7FFF, 16'h8000, 16'hFFFF));
    // Tiny negative products must floor to -1, not truncate to 0
    rows.push_back(reg_row(REG_G_SCALE_GAIN, 24'd3));
    rows.push_back(reg_row(REG_ZERO_G_OFFSET, 24'd1));
    rows.push_back(sample_row(16'h0000, 16'h0000, 16'h0000));
    rows.push_back(reg_row(REG_WALK_THRESHOLD, 24'd0));
    rows.push_back(sample_row(16'h0100, 16'h0000, 16'h0000));
    rows.push_back(reg_row(REG_WALK_THRESHOLD, 24'h00FFFF));
    rows.push_back(sample_row(16'h8000, 16'h8000, 16'h8000));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        drain_results();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
        close_reg_writes();
      end else begin
        fixed_res.walking = rows[i].walking;
        fixed_res.energy = rows[i].energy;
        send_sample(rows[i].x, rows[i].y, rows[i].z, idle_gap(), rows[i].fixed, fixed_res);
      end
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      case (phase)
        0: begin
          zero_v = 24'(ZERO_G_OFFSET_RST);
          gain_v = G_SCALE_GAIN_RST;
          thr_v = 24'(WALK_THRESHOLD_RST);
        end
        1: begin
          zero_v = 24'(int'($urandom_range(0, 4000)) - 2000);
          gain_v = 24'($urandom_range(40000, 100000));
          thr_v = 24'($urandom_range(50, 300));
        end
        2: begin
          zero_v = 24'h007FFF;
          gain_v = 24'h7FFFFF;
          thr_v = 24'd0;
        end
        3: begin
          zero_v = 24'hFF8000;
          gain_v = 24'h800000;
          thr_v = 24'h00FFFF;
        end
        4: begin
          zero_v = 24'($urandom);
          gain_v = 24'($urandom);
          thr_v = 24'($urandom);
        end
        5: begin
          zero_v = 24'($urandom);
          gain_v = 24'd0;
          thr_v = 24'd0;
        end
        default: begin
          zero_v = 24'(int'($urandom_range(0, 1000)) - 500);
          gain_v = G_SCALE_GAIN_RST;
          thr_v = 24'($urandom_range(0, 1000));
        end
      endcase
      write_reg(REG_ZERO_G_OFFSET, zero_v);
      write_reg(REG_G_SCALE_GAIN, gain_v);
      write_reg(REG_WALK_THRESHOLD, thr_v);
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNMAPPED, 24'($urandom));
      close_reg_writes();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        motion_sample(sx, sy, sz);
        // Back-to-back requests for the first part of every hundred
        send_sample(sx, sy, sz, (n % 100 < 30) ? 0 : idle_gap(), 1'b0, fixed_res);
      end
    end

    drain_results();
    repeat (2 * BLOCK_LATENCY) @(posedge clk);
    if (walk_results_due.size() != 0)
      report_mismatch("results never delivered", walk_results_due.size(), 0);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
